FILE: rtl/cvd_pkg.sv
// Shared types and constants for the class vote debounce block.
// No dependencies; every other file refers to this package by scoped names.
package cvd_pkg;

  localparam int CLASS_COUNT = 4;
  localparam int SCORE_W     = 8;
  localparam int CONF_W      = 25;
  localparam int CLASS_W     = 2;
  localparam int COUNT_W     = 4;
  localparam int THRESH_W    = 17;
  localparam int SCALE_W     = 16;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_IDX_W   = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCORE_OFFSET   = 2'd0,
    REG_SCALE_Q16      = 2'd1,
    REG_THRESHOLD_Q16  = 2'd2,
    REG_REQUIRED_COUNT = 2'd3
  } reg_index_t;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic signed [CONF_W-1:0]  conf_t;
  typedef logic [CLASS_W-1:0]        class_t;
  typedef logic [COUNT_W-1:0]        count_t;

  // Winner of the compare tree, handed to the debounce stage.
  typedef struct packed {
    class_t pick;
    conf_t  conf;
  } pick_t;

  // Decision settings used by the debounce stage.
  typedef struct packed {
    logic [THRESH_W-1:0] threshold;
    count_t              required;
  } vote_cfg_t;

endpackage

FILE: rtl/cvd_lane.sv
// One dequantization lane: (score - zero point) * scale, registered.
// Depends on cvd_pkg.
module cvd_lane (
  input  logic                          clk,
  input  logic                          load,
  input  cvd_pkg::score_t               score,
  input  cvd_pkg::score_t               offset,
  input  logic [cvd_pkg::SCALE_W-1:0]   scale,
  output cvd_pkg::conf_t                conf
);

  logic signed [cvd_pkg::SCORE_W:0]                   diff;
  logic signed [cvd_pkg::SCORE_W+cvd_pkg::SCALE_W+1:0] prod;

  assign diff = {score[cvd_pkg::SCORE_W-1], score}
              - {offset[cvd_pkg::SCORE_W-1], offset};
  assign prod = diff * $signed({1'b0, scale});

  always_ff @(posedge clk) begin
    if (load) begin
      // The product of a 9-bit difference and a 16-bit scale fits in 25 bits.
      conf <= prod[cvd_pkg::CONF_W-1:0];
    end
  end

endmodule

FILE: rtl/cvd_merge.sv
// Registered compare tree that finds the first highest of the lane results.
// Depends on cvd_pkg.
module cvd_merge (
  input  logic                                   clk,
  input  logic                                   load,
  input  cvd_pkg::conf_t [cvd_pkg::CLASS_COUNT-1:0] conf,
  output cvd_pkg::pick_t                         best
);

  cvd_pkg::conf_t lo_conf;
  cvd_pkg::conf_t hi_conf;
  cvd_pkg::class_t lo_pick;
  cvd_pkg::class_t hi_pick;
  cvd_pkg::pick_t  best_next;

  // A later class wins only on a strictly greater value, so ties keep the
  // lower index at every level of the tree.
  always_comb begin
    if (conf[1] > conf[0]) begin
      lo_conf = conf[1];
      lo_pick = cvd_pkg::class_t'(1);
    end else begin
      lo_conf = conf[0];
      lo_pick = cvd_pkg::class_t'(0);
    end
    if (conf[3] > conf[2]) begin
      hi_conf = conf[3];
      hi_pick = cvd_pkg::class_t'(3);
    end else begin
      hi_conf = conf[2];
      hi_pick = cvd_pkg::class_t'(2);
    end
    if (hi_conf > lo_conf) begin
      best_next.conf = hi_conf;
      best_next.pick = hi_pick;
    end else begin
      best_next.conf = lo_conf;
      best_next.pick = lo_pick;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      best <= best_next;
    end
  end

endmodule

FILE: rtl/cvd_debounce.sv
// Debounce state and output register: threshold test, candidate counter,
// stable class update. Depends on cvd_pkg.
module cvd_debounce (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  cvd_pkg::pick_t     best,
  input  cvd_pkg::vote_cfg_t cfg,
  output cvd_pkg::class_t    raw_pick,
  output cvd_pkg::conf_t     raw_conf,
  output logic               stable_known,
  output cvd_pkg::class_t    stable_pick,
  output cvd_pkg::conf_t     stable_conf,
  output logic               changed
);

  logic            stable_valid, stable_valid_next;
  cvd_pkg::class_t stable_class, stable_class_next;
  cvd_pkg::conf_t  stable_conf_reg, stable_conf_next;
  logic            cand_valid, cand_valid_next;
  cvd_pkg::class_t cand_class, cand_class_next;
  cvd_pkg::count_t cand_count, cand_count_next;
  logic            changed_next;

  cvd_pkg::count_t need;
  cvd_pkg::count_t count_bump;
  logic            below;

  assign need  = (cfg.required == '0) ? cvd_pkg::count_t'(1) : cfg.required;
  assign below = best.conf
               < $signed({{(cvd_pkg::CONF_W-cvd_pkg::THRESH_W){1'b0}}, cfg.threshold});

  always_comb begin
    stable_valid_next = stable_valid;
    stable_class_next = stable_class;
    stable_conf_next  = stable_conf_reg;
    cand_valid_next   = cand_valid;
    cand_class_next   = cand_class;
    cand_count_next   = cand_count;
    changed_next      = 1'b0;
    count_bump        = cand_count;

    if (below) begin
      cand_valid_next = 1'b0;
      cand_class_next = '0;
      cand_count_next = '0;
    end else if (stable_valid && best.pick == stable_class) begin
      stable_conf_next = best.conf;
      cand_valid_next  = 1'b0;
      cand_class_next  = '0;
      cand_count_next  = '0;
    end else begin
      if (cand_valid && best.pick == cand_class) begin
        count_bump = (cand_count == cvd_pkg::COUNT_MAX) ? cand_count
                                                        : cand_count + 1'b1;
      end else begin
        count_bump = cvd_pkg::count_t'(1);
      end
      if (count_bump >= need) begin
        stable_valid_next = 1'b1;
        stable_class_next = best.pick;
        stable_conf_next  = best.conf;
        cand_valid_next   = 1'b0;
        cand_class_next   = '0;
        cand_count_next   = '0;
        changed_next      = 1'b1;
      end else begin
        cand_valid_next = 1'b1;
        cand_class_next = best.pick;
        cand_count_next = count_bump;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_valid    <= 1'b0;
      stable_class    <= '0;
      stable_conf_reg <= '0;
      cand_valid      <= 1'b0;
      cand_class      <= '0;
      cand_count      <= '0;
      changed         <= 1'b0;
    end else if (load) begin
      stable_valid    <= stable_valid_next;
      stable_class    <= stable_class_next;
      stable_conf_reg <= stable_conf_next;
      cand_valid      <= cand_valid_next;
      cand_class      <= cand_class_next;
      cand_count      <= cand_count_next;
      changed         <= changed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      raw_pick <= best.pick;
      raw_conf <= best.conf;
    end
  end

  // The stable class and confidence stay zero until the first change.
  assign stable_known = stable_valid;
  assign stable_pick  = stable_class;
  assign stable_conf  = stable_conf_reg;

  a_cand_clear: assert property (@(posedge clk) disable iff (rst)
    !cand_valid |-> (cand_count == '0 && cand_class == '0))
    else $error("idle candidate holds a count or class");

  a_change_sets_stable: assert property (@(posedge clk) disable iff (rst)
    changed |-> (stable_valid && stable_class == raw_pick && stable_conf_reg == raw_conf))
    else $error("change flag without matching stable class");

  a_cand_not_stable: assert property (@(posedge clk) disable iff (rst)
    (cand_valid && stable_valid) |-> (cand_class != stable_class))
    else $error("candidate equals the stable class");

  a_stable_sticky: assert property (@(posedge clk) disable iff (rst)
    stable_valid |=> stable_valid)
    else $error("stable class lost");

endmodule

FILE: rtl/class_vote_debounce.sv
// Top level of the class vote debounce block: configuration registers,
// four dequantization lanes, compare tree and debounce stage with handshakes.
// Depends on cvd_pkg, cvd_lane, cvd_merge and cvd_debounce.
//
//   channel  | direction | handshake          | payload
//   s_axis   | in        | s_tvalid/s_tready  | s_tdata: four int8 class scores
//   m_axis   | out       | m_tvalid/m_tready  | m_tdata: pick, confidences, flags
//   cfg      | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An accepted request is registered in turn by the lane multiplier, the compare
// tree and the debounce update, one register stage each, before it is presented
// on m_tdata.
// A new request is accepted every cycle while results drain.
// Each stage holds only when it is full and the stage after it is stalled.
// Reset clears the debounce state and the stage valids and restores the
// default configuration; cfg_ready is always high.
module class_vote_debounce (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // score_empty [7:0], score_reading [15:8], score_sleep [23:16], score_active [31:24]
  input  logic [31:0]                     s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // raw_pick [1:0], raw_conf [26:2], stable_known [27], stable_pick [29:28],
  // stable_conf [54:30], changed [55]
  output logic [55:0]                     m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cvd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cvd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  cvd_pkg::score_t                 score_offset;
  logic [cvd_pkg::SCALE_W-1:0]     scale_q16;
  logic [cvd_pkg::THRESH_W-1:0]    threshold_q16;
  cvd_pkg::count_t                 required_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_offset   <= '0;
      scale_q16      <= cvd_pkg::SCALE_W'(256);
      threshold_q16  <= cvd_pkg::THRESH_W'(39322);
      required_count <= cvd_pkg::count_t'(3);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cvd_pkg::reg_index_t'(cfg_index))
        cvd_pkg::REG_SCORE_OFFSET:   score_offset   <= cfg_data[cvd_pkg::SCORE_W-1:0];
        cvd_pkg::REG_SCALE_Q16:      scale_q16      <= cfg_data[cvd_pkg::SCALE_W-1:0];
        cvd_pkg::REG_THRESHOLD_Q16:  threshold_q16  <= cfg_data[cvd_pkg::THRESH_W-1:0];
        cvd_pkg::REG_REQUIRED_COUNT: required_count <= cfg_data[cvd_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valids: lanes, compare tree, output.
  logic v1, v2, v3;
  logic r1, r2, r3;
  logic ld1, ld2, ld3;

  assign r3  = !v3 || m_tready;
  assign r2  = !v2 || r3;
  assign r1  = !v1 || r2;
  assign ld1 = s_tvalid && r1;
  assign ld2 = v1 && r2;
  assign ld3 = v2 && r3;
  assign s_tready = r1;
  assign m_tvalid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= s_tvalid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  cvd_pkg::conf_t [cvd_pkg::CLASS_COUNT-1:0] lane_conf;

  for (genvar g = 0; g < cvd_pkg::CLASS_COUNT; g++) begin : g_lane
    cvd_lane u_lane (
      .clk        (clk),
      .load       (ld1),
      .score      (s_tdata[g*cvd_pkg::SCORE_W +: cvd_pkg::SCORE_W]),
      .offset     (score_offset),
      .scale      (scale_q16),
      .conf       (lane_conf[g])
    );
  end

  cvd_pkg::pick_t best;

  cvd_merge u_merge (
    .clk  (clk),
    .load (ld2),
    .conf (lane_conf),
    .best (best)
  );

  cvd_pkg::vote_cfg_t vote_cfg;
  cvd_pkg::class_t    raw_pick, stable_pick;
  cvd_pkg::conf_t     raw_conf, stable_conf;
  logic               stable_known, changed;

  assign vote_cfg.threshold = threshold_q16;
  assign vote_cfg.required  = required_count;

  cvd_debounce u_debounce (
    .clk          (clk),
    .rst          (rst),
    .load         (ld3),
    .best         (best),
    .cfg          (vote_cfg),
    .raw_pick     (raw_pick),
    .raw_conf     (raw_conf),
    .stable_known (stable_known),
    .stable_pick  (stable_pick),
    .stable_conf  (stable_conf),
    .changed      (changed)
  );

  assign m_tdata = {changed, stable_conf, stable_pick, stable_known, raw_conf, raw_pick};

endmodule

FILE: tb/tb_class_vote_debounce.sv
// Self-checking testbench for class_vote_debounce: directed and random score requests
// are checked against a behavioral predictor of the argmax and debounce logic.
// Depends on cvd_pkg and the class_vote_debounce RTL.
module tb_class_vote_debounce;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_LIMIT  = 40;

  typedef struct packed {
    cvd_pkg::class_t raw_pick;
    cvd_pkg::conf_t  raw_conf;
    logic            stable_known;
    cvd_pkg::class_t stable_pick;
    cvd_pkg::conf_t  stable_conf;
    logic            changed;
  } vote_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [31:0]                    s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [55:0]                    m_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [cvd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [cvd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  class_vote_debounce dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the configuration, starting at the reset defaults.
  int cfg_offset    = 0;
  int cfg_scale     = 256;
  int cfg_threshold = 39322;
  int cfg_required  = 3;

  // Predictor copy of the debounce state.
  logic            stable_set   = 1'b0;
  cvd_pkg::class_t stable_class = '0;
  int              stable_conf  = 0;
  logic            cand_set     = 1'b0;
  cvd_pkg::class_t cand_class   = '0;
  int              cand_count   = 0;

  vote_result_t expected_votes[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;
  int mismatches     = 0;
  int requests_sent  = 0;
  int results_seen   = 0;
  int class_changes  = 0;
  int config_writes  = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_votes.size());
      $display("class_vote_debounce: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic vote_result_t classify_and_debounce(input logic [31:0] data);
    int              conf [cvd_pkg::CLASS_COUNT];
    int              top_conf;
    cvd_pkg::class_t best;
    int              need;
    logic            changed;
    vote_result_t    r;
    for (int i = 0; i < cvd_pkg::CLASS_COUNT; i++)
      conf[i] = (int'($signed(data[8*i +: 8])) - cfg_offset) * cfg_scale;
    best     = '0;
    top_conf = conf[0];
    changed  = 1'b0;
    // Strictly greater, so the lowest index keeps a tie.
    for (int i = 1; i < cvd_pkg::CLASS_COUNT; i++) begin
      if (conf[i] > top_conf) begin
        top_conf = conf[i];
        best     = cvd_pkg::class_t'(i);
      end
    end
    need = (cfg_required == 0) ? 1 : cfg_required;
    if (top_conf < cfg_threshold) begin
      cand_set   = 1'b0;
      cand_class = '0;
      cand_count = 0;
    end else if (stable_set && best == stable_class) begin
      stable_conf = top_conf;
      cand_set    = 1'b0;
      cand_class  = '0;
      cand_count  = 0;
    end else begin
      if (cand_set && best == cand_class) begin
        if (cand_count < 15) cand_count++;
      end else begin
        cand_set   = 1'b1;
        cand_class = best;
        cand_count = 1;
      end
      if (cand_count >= need) begin
        stable_set   = 1'b1;
        stable_class = cand_class;
        stable_conf  = top_conf;
        cand_set     = 1'b0;
        cand_class   = '0;
        cand_count   = 0;
        changed      = 1'b1;
      end
    end
    r.raw_pick     = best;
    r.raw_conf     = cvd_pkg::conf_t'(top_conf);
    r.stable_known = stable_set;
    r.stable_pick  = stable_set ? stable_class : cvd_pkg::class_t'(0);
    r.stable_conf  = stable_set ? cvd_pkg::conf_t'(stable_conf) : cvd_pkg::conf_t'(0);
    r.changed      = changed;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    if (mismatches < PRINT_LIMIT)
      $display("result %0d: %s expected %0d, got %0d", results_seen, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    vote_result_t want;
    vote_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.raw_pick     = m_tdata[1:0];
      got.raw_conf     = m_tdata[26:2];
      got.stable_known = m_tdata[27];
      got.stable_pick  = m_tdata[29:28];
      got.stable_conf  = m_tdata[54:30];
      got.changed      = m_tdata[55];
      if (expected_votes.size() == 0) begin
        report_mismatch("result with no request pending", 0, 1);
      end else begin
        want = expected_votes.pop_front();
        if (want.changed) class_changes++;
        if (got.raw_pick !== want.raw_pick)
          report_mismatch("raw_pick", want.raw_pick, got.raw_pick);
        if (got.raw_conf !== want.raw_conf)
          report_mismatch("raw_conf", want.raw_conf, got.raw_conf);
        if (got.stable_known !== want.stable_known)
          report_mismatch("stable_known", want.stable_known, got.stable_known);
        if (got.stable_pick !== want.stable_pick)
          report_mismatch("stable_pick", want.stable_pick, got.stable_pick);
        if (got.stable_conf !== want.stable_conf)
          report_mismatch("stable_conf", want.stable_conf, got.stable_conf);
        if (got.changed !== want.changed)
          report_mismatch("changed", want.changed, got.changed);
      end
      results_seen++;
    end
  end

  function automatic logic [31:0] pack_scores(input int e, input int r, input int s,
                                              input int a);
    return {a[7:0], s[7:0], r[7:0], e[7:0]};
  endfunction

  // s_tvalid is lowered only when the next request is held back, so it never
  // gets two assignments in one step.
  task automatic send_scores(input logic [31:0] data);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_votes.push_back(classify_and_debounce(data));
    requests_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_votes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cvd_pkg::reg_index_t idx,
                           input logic [cvd_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      cvd_pkg::REG_SCORE_OFFSET:   cfg_offset    = int'($signed(value[7:0]));
      cvd_pkg::REG_SCALE_Q16:      cfg_scale     = int'(value[15:0]);
      cvd_pkg::REG_THRESHOLD_Q16:  cfg_threshold = int'(value[16:0]);
      cvd_pkg::REG_REQUIRED_COUNT: cfg_required  = int'(value[3:0]);
      default: ;
    endcase
    config_writes++;
  endtask

  // Unused upper bits of the write data carry random values; the block must ignore them.
  task automatic set_config(input int zp, input int scale, input int thr, input int req);
    logic [16:0] junk;
    wait_drained();
    junk = 17'($urandom);
    write_reg(cvd_pkg::REG_SCORE_OFFSET,   {junk[16:8], zp[7:0]});
    write_reg(cvd_pkg::REG_SCALE_Q16,      {junk[0], scale[15:0]});
    write_reg(cvd_pkg::REG_THRESHOLD_Q16,  thr[16:0]);
    write_reg(cvd_pkg::REG_REQUIRED_COUNT, {junk[16:4], req[3:0]});
    cfg_valid <= 1'b0;
  endtask

  // Reset defaults leave the best possible confidence under the threshold.
  task automatic test_reset_defaults();
    send_scores(pack_scores(127, 127, 127, 127));
    send_scores(pack_scores(-128, -128, -128, -128));
    send_scores(pack_scores(-128, 127, 0, 127));
  endtask

  task automatic test_extreme_scores_and_ties();
    set_config(-128, 65535, 65536, 1);
    send_scores(pack_scores(-128, -128, -128, -128));
    send_scores(pack_scores(127, 127, 127, 127));
    send_scores(pack_scores(-128, -128, -128, 127));
    send_scores(pack_scores(100, 127, 127, 100));
    send_scores(pack_scores(-128, 127, -128, -128));
  endtask

  task automatic test_threshold_cases();
    // A threshold of 0 rejects negative confidences but accepts zero; a required
    // count of 0 changes class on the first confident pick.
    set_config(127, 65535, 0, 0);
    send_scores(pack_scores(-128, -128, -128, -128));
    send_scores(pack_scores(-128, 127, 127, 127));
    send_scores(pack_scores(-128, -128, -1, -128));
    // Zero scale: every confidence is zero and class 0 wins.
    set_config(5, 0, 0, 2);
    send_scores(pack_scores(-77, 12, 127, -128));
    send_scores(pack_scores(3, 127, -5, 90));
    // Largest threshold the register holds; score 0 lands just above it.
    set_config(-128, 1024, 131071, 2);
    send_scores(pack_scores(-128, -128, -128, 0));
    send_scores(pack_scores(-128, -128, -128, -1));
    send_scores(pack_scores(-128, -128, -128, 0));
    send_scores(pack_scores(-128, -128, -128, 0));
  endtask

  task automatic test_debounce_runs();
    set_config(-128, 256, 39322, 3);
    send_scores(pack_scores(0, 0, 100, 0));
    send_scores(pack_scores(0, 0, 100, 0));
    send_scores(pack_scores(0, 100, 0, 0));
    send_scores(pack_scores(0, 100, 0, 0));
    send_scores(pack_scores(0, 100, 0, 0));
    send_scores(pack_scores(0, 50, 0, 0));
    send_scores(pack_scores(0, 0, 100, 0));
    send_scores(pack_scores(-128, -128, -128, -128));
  endtask

  task automatic random_config(output int level, output int need);
    int     zp;
    int     scale;
    int     thr;
    int     req;
    longint span;
    zp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) - 128
                                     : $urandom_range(0, 100) - 128;
    case ($urandom_range(0, 7))
      0:       scale = 0;
      1:       scale = 65535;
      2, 3:    scale = $urandom_range(1, 2048);
      default: scale = $urandom_range(0, 65535);
    endcase
    // The threshold mostly sits at the confidence of a chosen score level, clamped to the register range.
    level = $urandom_range(0, 255) - 128;
    span  = longint'(level - zp) * scale;
    if ($urandom_range(0, 9) == 0) thr = $urandom_range(0, 131071);
    else if (span < 0)             thr = 0;
    else if (span > 131071)        thr = 131071;
    else                           thr = int'(span);
    req  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
    need = (req == 0) ? 1 : req;
    set_config(zp, scale, thr, req);
  endtask

  // A run favors one class with scores at or above the threshold level; some
  // requests are plain noise that breaks the run.
  task automatic send_random_run(input int level, input int run_len);
    int          fav;
    int          hi;
    int          other;
    logic [31:0] data;
    fav = $urandom_range(0, 3);
    for (int j = 0; j < run_len; j++) begin
      if ($urandom_range(0, 99) < 15) begin
        data = $urandom;
      end else begin
        hi = level + $urandom_range(0, 127 - level);
        for (int k = 0; k < cvd_pkg::CLASS_COUNT; k++) begin
          other = -128 + $urandom_range(0, hi + 128);
          data[8*k +: 8] = (k == fav) ? hi[7:0] : other[7:0];
        end
      end
      send_scores(data);
    end
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int total);
    int sent_here;
    int per_cfg;
    int level;
    int need;
    int len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent_here      = 0;
    while (sent_here < total) begin
      random_config(level, need);
      per_cfg = 0;
      while (per_cfg < total / 2 && sent_here < total) begin
        len = $urandom_range(1, need + 2);
        send_random_run(level, len);
        per_cfg   += len;
        sent_here += len;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_extreme_scores_and_ties();
    test_threshold_cases();
    test_debounce_runs();
    test_random_traffic(34, 82, 134);
    test_random_traffic(82, 34, 134);
    test_random_traffic(0, 0, 134);
    wait_drained();
    $display("covered %0d score requests and %0d results under %0d register writes,",
             requests_sent, results_seen, config_writes);
    $display("with %0d stable class changes across three idle and stall mixes",
             class_changes);
    if (mismatches == 0) begin
      $display("class_vote_debounce: match");
    end else begin
      $display("%0d field mismatches", mismatches);
      $display("class_vote_debounce: mismatch");
    end
    $finish;
  end

endmodule

FILE: class_vote_debounce.f
rtl/cvd_pkg.sv
rtl/cvd_lane.sv
rtl/cvd_merge.sv
rtl/cvd_debounce.sv
rtl/class_vote_debounce.sv
tb/tb_class_vote_debounce.sv
